/* src/rci_pkg.sv */
// shared constants, types and helper functions of the ray versus cylinder pipeline
// no dependencies; imported by ray_cylinder_intersection
`timescale 1ns / 1ps

package rci_pkg;

	// fixed point format
	localparam int FRAC_BITS = 16;

	// field widths
	localparam int VAL_W  = 32;
	localparam int DIR_W  = 18;
	localparam int RAD_W  = 31;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_PX  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_PY  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_PZ  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_DX  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_DY  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_DZ  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 4'd7;

	// reset values for 1.0
	localparam logic [63:0] ONE_FIX = 64'd1 << FRAC_BITS;
	localparam logic [DIR_W-1:0] AXIS_ONE = ONE_FIX[DIR_W-1:0];
	localparam logic [RAD_W-1:0] RAD_ONE  = ONE_FIX[RAD_W-1:0];

	// axial projection widths
	localparam int DP_W   = VAL_W + 1;
	localparam int PD_W   = DP_W + DIR_W;
	localparam int SUM_W  = PD_W + 2;
	localparam int Q_W    = SUM_W + 1 - FRAC_BITS;
	localparam int QP_W   = Q_W + DIR_W;
	localparam int WIDE_W = 72;

	// quadratic terms
	localparam int SQ_W   = 2 * VAL_W;
	localparam int RR_W   = 2 * RAD_W;
	localparam int H_W    = SQ_W + 2;
	localparam int X_W    = SQ_W + 1;
	localparam int D_W    = 4 * VAL_W;
	localparam int SQ_BITS = SQ_W;

	// root division
	localparam int NUM_W = SQ_W + 3;
	localparam int MAG_W = SQ_W + 1;
	localparam int QB    = VAL_W - 1;
	localparam int REM_W = SQ_W + QB + 1;

	localparam logic [VAL_W-1:0] T_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] T_MIN = 32'h8000_0000;

	localparam logic signed [WIDE_W-1:0] SAT_MAX = 72'sh7FFF_FFFF;
	localparam logic signed [WIDE_W-1:0] SAT_MIN = -72'sh8000_0000;

	// ray origin and direction
	typedef struct packed {
		logic [2:0][VAL_W-1:0] o;
		logic [2:0][VAL_W-1:0] d;
	} ray_t;

	// side data that travels with an item
	typedef struct packed {
		ray_t             ray;
		logic [SQ_W-1:0]  a;
		logic [X_W-1:0]   x;
		logic             miss;
	} carry_t;

	// one restoring divider lane
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QB-1:0]    q;
		logic             sat;
		logic             neg;
	} div_t;

	// round half up to FRAC_BITS fraction bits
	function automatic logic signed [WIDE_W-1:0] rnd_shr(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] half;
		half = WIDE_W'(1) <<< (FRAC_BITS - 1);
		return (v + half) >>> FRAC_BITS;
	endfunction

	// clamp to the signed 32 bit range
	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		if (v > SAT_MAX) return T_MAX;
		if (v < SAT_MIN) return T_MIN;
		return VAL_W'(v);
	endfunction

endpackage

/* src/ray_cylinder_intersection.sv */
// ray versus infinite cylinder intersection, fully pipelined
// depends on rci_pkg
`timescale 1ns / 1ps

// One ray enters per clock unless a result waits at a stalled output; its result leaves
// from the s112 output register. The depth is set by the integer square root of the
// discriminant (64 stages, one root bit each) and the two root divisions that run side
// by side (one compare stage plus 31 stages, one quotient bit each). A stalled output
// holds the whole pipeline, so in_stall follows out_stall while a result waits. The
// cylinder registers are written on the plain write port and are meant to change only
// while no ray is in flight. A miss returns hit, distance and point all zero.
module ray_cylinder_intersection (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rci_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rci_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [rci_pkg::VAL_W-1:0]     ray_origin_x,
	input  logic signed [rci_pkg::VAL_W-1:0]     ray_origin_y,
	input  logic signed [rci_pkg::VAL_W-1:0]     ray_origin_z,
	input  logic signed [rci_pkg::VAL_W-1:0]     ray_dir_x,
	input  logic signed [rci_pkg::VAL_W-1:0]     ray_dir_y,
	input  logic signed [rci_pkg::VAL_W-1:0]     ray_dir_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 hit,
	output logic signed [rci_pkg::VAL_W-1:0]     hit_distance,
	output logic signed [rci_pkg::VAL_W-1:0]     hit_x,
	output logic signed [rci_pkg::VAL_W-1:0]     hit_y,
	output logic signed [rci_pkg::VAL_W-1:0]     hit_z
);
	import rci_pkg::*;

	// configuration registers
	logic signed [VAL_W-1:0] axis_p_q [3];
	logic signed [DIR_W-1:0] axis_n_q [3];
	logic        [RAD_W-1:0] radius_q;
	logic signed [VAL_W-1:0] tmin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_p_q[0] <= '0;
			axis_p_q[1] <= '0;
			axis_p_q[2] <= '0;
			axis_n_q[0] <= '0;
			axis_n_q[1] <= '0;
			axis_n_q[2] <= AXIS_ONE;
			radius_q    <= RAD_ONE;
			tmin_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AXIS_PX:  axis_p_q[0] <= cfg_data[VAL_W-1:0];
				REG_AXIS_PY:  axis_p_q[1] <= cfg_data[VAL_W-1:0];
				REG_AXIS_PZ:  axis_p_q[2] <= cfg_data[VAL_W-1:0];
				REG_AXIS_DX:  axis_n_q[0] <= cfg_data[DIR_W-1:0];
				REG_AXIS_DY:  axis_n_q[1] <= cfg_data[DIR_W-1:0];
				REG_AXIS_DZ:  axis_n_q[2] <= cfg_data[DIR_W-1:0];
				REG_RADIUS:   radius_q    <= cfg_data[RAD_W-1:0];
				REG_MIN_DIST: tmin_q      <= cfg_data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// global advance: the output register is free or being taken
	logic en;
	logic out_valid_s112;

	assign en       = !out_valid_s112 || !out_stall;
	assign in_stall = !en;

	// input gathering
	ray_t                    ray_in;
	logic signed [DP_W-1:0]  dp_in [3];

	always_comb begin
		ray_in.o[0] = ray_origin_x;
		ray_in.o[1] = ray_origin_y;
		ray_in.o[2] = ray_origin_z;
		ray_in.d[0] = ray_dir_x;
		ray_in.d[1] = ray_dir_y;
		ray_in.d[2] = ray_dir_z;
		for (int i = 0; i < 3; i++)
			dp_in[i] = DP_W'($signed(ray_in.o[i])) - DP_W'(axis_p_q[i]);
	end

	// stage valid bits of the front part
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <=
				{in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8};
		end
	end

	// s1: dot product terms against the axis
	ray_t                    ray_s1;
	logic signed [DP_W-1:0]  dp_s1 [3];
	logic signed [PD_W-1:0]  pd_s1 [3];
	logic signed [PD_W-1:0]  pc_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= ray_in;
			for (int i = 0; i < 3; i++) begin
				dp_s1[i] <= dp_in[i];
				pd_s1[i] <= $signed(ray_in.d[i]) * axis_n_q[i];
				pc_s1[i] <= dp_in[i] * axis_n_q[i];
			end
		end
	end

	// s2: axial length, rounded
	ray_t                    ray_s2;
	logic signed [DP_W-1:0]  dp_s2 [3];
	logic signed [Q_W-1:0]   qd_s2, qc_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s2 <= ray_s1;
			dp_s2  <= dp_s1;
			qd_s2  <= Q_W'(rnd_shr(WIDE_W'(pd_s1[0]) + WIDE_W'(pd_s1[1]) + WIDE_W'(pd_s1[2])));
			qc_s2  <= Q_W'(rnd_shr(WIDE_W'(pc_s1[0]) + WIDE_W'(pc_s1[1]) + WIDE_W'(pc_s1[2])));
		end
	end

	// s3: axial components
	ray_t                    ray_s3;
	logic signed [DP_W-1:0]  dp_s3 [3];
	logic signed [QP_W-1:0]  apd_s3 [3];
	logic signed [QP_W-1:0]  apc_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s3 <= ray_s2;
			dp_s3  <= dp_s2;
			for (int i = 0; i < 3; i++) begin
				apd_s3[i] <= qd_s2 * axis_n_q[i];
				apc_s3[i] <= qc_s2 * axis_n_q[i];
			end
		end
	end

	// s4: perpendicular vectors a and c
	ray_t                    ray_s4;
	logic signed [VAL_W-1:0] av_s4 [3];
	logic signed [VAL_W-1:0] cv_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s4 <= ray_s3;
			for (int i = 0; i < 3; i++) begin
				av_s4[i] <= sat32(WIDE_W'($signed(ray_s3.d[i])) - rnd_shr(WIDE_W'(apd_s3[i])));
				cv_s4[i] <= sat32(WIDE_W'(dp_s3[i]) - rnd_shr(WIDE_W'(apc_s3[i])));
			end
		end
	end

	// s5: component products and radius squared
	ray_t                    ray_s5;
	logic signed [SQ_W-1:0]  paa_s5 [3];
	logic signed [SQ_W-1:0]  pcc_s5 [3];
	logic signed [SQ_W-1:0]  pac_s5 [3];
	logic        [RR_W-1:0]  rr_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s5 <= ray_s4;
			rr_s5  <= RR_W'(radius_q) * RR_W'(radius_q);
			for (int i = 0; i < 3; i++) begin
				paa_s5[i] <= av_s4[i] * av_s4[i];
				pcc_s5[i] <= cv_s4[i] * cv_s4[i];
				pac_s5[i] <= av_s4[i] * cv_s4[i];
			end
		end
	end

	// s6: A = a.a, c.c and h = a.c
	ray_t                    ray_s6;
	logic        [SQ_W-1:0]  a_s6, cc_s6;
	logic signed [H_W-1:0]   h_s6;
	logic        [RR_W-1:0]  rr_s6;
	logic signed [H_W-1:0]   a_sum, cc_sum;

	always_comb begin
		a_sum  = H_W'(paa_s5[0]) + H_W'(paa_s5[1]) + H_W'(paa_s5[2]);
		cc_sum = H_W'(pcc_s5[0]) + H_W'(pcc_s5[1]) + H_W'(pcc_s5[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s6 <= ray_s5;
			rr_s6  <= rr_s5;
			a_s6   <= a_sum[SQ_W-1:0];
			cc_s6  <= cc_sum[SQ_W-1:0];
			h_s6   <= H_W'(pac_s5[0]) + H_W'(pac_s5[1]) + H_W'(pac_s5[2]);
		end
	end

	// s7: |h|, -h and |c.c - r*r| with its sign
	carry_t                  c_s7;
	logic        [SQ_W-1:0]  hmag_s7, em_s7;
	logic                    eneg_s7;
	logic signed [H_W-1:0]   hneg_v;
	logic                    cc_ge;

	always_comb begin
		hneg_v = -h_s6;
		cc_ge  = cc_s6 >= SQ_W'(rr_s6);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s7.ray  <= ray_s6;
			c_s7.a    <= a_s6;
			c_s7.x    <= hneg_v[X_W-1:0];
			c_s7.miss <= a_s6 == '0;
			hmag_s7   <= h_s6[H_W-1] ? hneg_v[SQ_W-1:0] : h_s6[SQ_W-1:0];
			em_s7     <= cc_ge ? cc_s6 - SQ_W'(rr_s6) : SQ_W'(rr_s6) - cc_s6;
			eneg_s7   <= !cc_ge;
		end
	end

	// s8: 32 by 32 partial products of h*h and A*|e|
	localparam int HW = SQ_W / 2;
	carry_t                  c_s8;
	logic                    eneg_s8;
	logic [SQ_W-1:0]         hp00_s8, hp01_s8, hp11_s8;
	logic [SQ_W-1:0]         ap00_s8, ap01_s8, ap10_s8, ap11_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8    <= c_s7;
			eneg_s8 <= eneg_s7;
			hp00_s8 <= hmag_s7[HW-1:0]    * hmag_s7[HW-1:0];
			hp01_s8 <= hmag_s7[HW-1:0]    * hmag_s7[SQ_W-1:HW];
			hp11_s8 <= hmag_s7[SQ_W-1:HW] * hmag_s7[SQ_W-1:HW];
			ap00_s8 <= c_s7.a[HW-1:0]     * em_s7[HW-1:0];
			ap01_s8 <= c_s7.a[HW-1:0]     * em_s7[SQ_W-1:HW];
			ap10_s8 <= c_s7.a[SQ_W-1:HW]  * em_s7[HW-1:0];
			ap11_s8 <= c_s7.a[SQ_W-1:HW]  * em_s7[SQ_W-1:HW];
		end
	end

	// s9: full 128 bit products
	carry_t                  c_s9;
	logic                    eneg_s9;
	logic [D_W-1:0]          hh_s9, ae_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s9    <= c_s8;
			eneg_s9 <= eneg_s8;
			hh_s9   <= {hp11_s8, {SQ_W{1'b0}}} + (D_W'(hp01_s8) << (HW + 1)) + D_W'(hp00_s8);
			ae_s9   <= {ap11_s8, {SQ_W{1'b0}}} + ((D_W'(ap01_s8) + D_W'(ap10_s8)) << HW)
				+ D_W'(ap00_s8);
		end
	end

	// square root pipeline, entry 0 is s10 (quarter discriminant)
	logic               sqrt_v_s   [SQ_BITS+1];
	logic [D_W-1:0]     sqrt_rem_s [SQ_BITS+1];
	logic [SQ_BITS-1:0] sqrt_res_s [SQ_BITS+1];
	carry_t             sqrt_c_s   [SQ_BITS+1];
	carry_t             sqrt_c_in;

	// negative discriminant joins the miss flag
	always_comb begin
		sqrt_c_in      = c_s9;
		sqrt_c_in.miss = c_s9.miss || (!eneg_s9 && hh_s9 < ae_s9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sqrt_v_s[0] <= 1'b0;
		else if (en) sqrt_v_s[0] <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqrt_c_s[0]     <= sqrt_c_in;
			sqrt_res_s[0]   <= '0;
			sqrt_rem_s[0]   <= eneg_s9 ? hh_s9 + ae_s9 : hh_s9 - ae_s9;
		end
	end

	// one root bit per stage, remainder kept as value minus root squared
	for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
		localparam int B = SQ_BITS - 1 - k;
		logic [D_W-1:0] trial;

		assign trial = (D_W'(sqrt_res_s[k]) << (B + 1)) | (D_W'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqrt_v_s[k+1] <= 1'b0;
			else if (en) sqrt_v_s[k+1] <= sqrt_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqrt_c_s[k+1] <= sqrt_c_s[k];
				if (sqrt_rem_s[k] >= trial) begin
					sqrt_rem_s[k+1] <= sqrt_rem_s[k] - trial;
					sqrt_res_s[k+1] <= sqrt_res_s[k] | (SQ_BITS'(1) << B);
				end else begin
					sqrt_rem_s[k+1] <= sqrt_rem_s[k];
					sqrt_res_s[k+1] <= sqrt_res_s[k];
				end
			end
		end
	end

	// s75: numerators -h - s and -h + s
	logic                    v_s75, v_s76;
	carry_t                  c_s75, c_s76;
	logic signed [NUM_W-1:0] numn_s75, numf_s75;
	logic signed [NUM_W-1:0] s_ext;

	assign s_ext = $signed({{(NUM_W - SQ_BITS){1'b0}}, sqrt_res_s[SQ_BITS]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s75 <= 1'b0;
			v_s76 <= 1'b0;
		end else if (en) begin
			v_s75 <= sqrt_v_s[SQ_BITS];
			v_s76 <= v_s75;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s75    <= sqrt_c_s[SQ_BITS];
			numn_s75 <= NUM_W'($signed(sqrt_c_s[SQ_BITS].x)) - s_ext;
			numf_s75 <= NUM_W'($signed(sqrt_c_s[SQ_BITS].x)) + s_ext;
		end
	end

	// s76: sign and magnitude of each numerator
	logic [MAG_W-1:0]        magn_s76, magf_s76;
	logic                    negn_s76, negf_s76;
	logic signed [NUM_W-1:0] numn_neg, numf_neg;

	always_comb begin
		numn_neg = -numn_s75;
		numf_neg = -numf_s75;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s76    <= c_s75;
			negn_s76 <= numn_s75[NUM_W-1];
			negf_s76 <= numf_s75[NUM_W-1];
			magn_s76 <= numn_s75[NUM_W-1] ? numn_neg[MAG_W-1:0] : numn_s75[MAG_W-1:0];
			magf_s76 <= numf_s75[NUM_W-1] ? numf_neg[MAG_W-1:0] : numf_s75[MAG_W-1:0];
		end
	end

	// divider pipeline, entry 0 is s77 (overflow check of the quotient)
	logic   div_v_s [QB+1];
	carry_t div_c_s [QB+1];
	div_t   divn_s  [QB+1];
	div_t   divf_s  [QB+1];
	logic [REM_W-1:0] nn_ext, nf_ext, a_lim;

	always_comb begin
		nn_ext = REM_W'(magn_s76) << FRAC_BITS;
		nf_ext = REM_W'(magf_s76) << FRAC_BITS;
		a_lim  = REM_W'(c_s76.a) << QB;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_v_s[0] <= 1'b0;
		else if (en) div_v_s[0] <= v_s76;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_c_s[0]     <= c_s76;
			divn_s[0].rem  <= nn_ext;
			divn_s[0].q    <= '0;
			divn_s[0].sat  <= nn_ext >= a_lim;
			divn_s[0].neg  <= negn_s76;
			divf_s[0].rem  <= nf_ext;
			divf_s[0].q    <= '0;
			divf_s[0].sat  <= nf_ext >= a_lim;
			divf_s[0].neg  <= negf_s76;
		end
	end

	// one quotient bit per stage for both roots
	for (genvar j = 1; j <= QB; j++) begin : g_div
		localparam int I = QB - j;
		logic [REM_W-1:0] trial;
		logic             gen, gef;

		always_comb begin
			trial = REM_W'(div_c_s[j-1].a) << I;
			gen   = divn_s[j-1].rem >= trial;
			gef   = divf_s[j-1].rem >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_v_s[j] <= 1'b0;
			else if (en) div_v_s[j] <= div_v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_c_s[j]     <= div_c_s[j-1];
				divn_s[j].sat  <= divn_s[j-1].sat;
				divn_s[j].neg  <= divn_s[j-1].neg;
				divn_s[j].q    <= {divn_s[j-1].q[QB-2:0], gen};
				divn_s[j].rem  <= gen ? divn_s[j-1].rem - trial : divn_s[j-1].rem;
				divf_s[j].sat  <= divf_s[j-1].sat;
				divf_s[j].neg  <= divf_s[j-1].neg;
				divf_s[j].q    <= {divf_s[j-1].q[QB-2:0], gef};
				divf_s[j].rem  <= gef ? divf_s[j-1].rem - trial : divf_s[j-1].rem;
			end
		end
	end

	// floored, saturated root from quotient, remainder and sign
	function automatic logic signed [VAL_W-1:0] root_t(input div_t r);
		logic [VAL_W-1:0] qz;
		qz = {1'b0, r.q};
		if (r.sat) return r.neg ? T_MIN : T_MAX;
		if (r.neg) return -qz - VAL_W'(|r.rem);
		return qz;
	endfunction

	// s109: both roots
	logic                    v_s109, v_s110, v_s111;
	carry_t                  c_s109;
	logic signed [VAL_W-1:0] tn_s109, tf_s109;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s109         <= 1'b0;
			v_s110         <= 1'b0;
			v_s111         <= 1'b0;
			out_valid_s112 <= 1'b0;
		end else if (en) begin
			v_s109         <= div_v_s[QB];
			v_s110         <= v_s109;
			v_s111         <= v_s110;
			out_valid_s112 <= v_s111;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s109  <= div_c_s[QB];
			tn_s109 <= root_t(divn_s[QB]);
			tf_s109 <= root_t(divf_s[QB]);
		end
	end

	// s110: pick the nearer root that is not below the minimum distance
	ray_t                    ray_s110, ray_s111;
	logic                    hit_s110, hit_s111;
	logic signed [VAL_W-1:0] t_s110, t_s111;
	logic                    near_ok, far_ok;

	always_comb begin
		near_ok = tn_s109 >= tmin_q;
		far_ok  = tf_s109 >= tmin_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s110 <= c_s109.ray;
			hit_s110 <= !c_s109.miss && (near_ok || far_ok);
			t_s110   <= near_ok ? tn_s109 : tf_s109;
		end
	end

	// s111: t times direction
	logic signed [SQ_W-1:0]  tp_s111 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s111 <= ray_s110;
			hit_s111 <= hit_s110;
			t_s111   <= t_s110;
			for (int i = 0; i < 3; i++)
				tp_s111[i] <= t_s110 * $signed(ray_s110.d[i]);
		end
	end

	// s112: output register, zero on a miss
	logic                    hit_s112;
	logic signed [VAL_W-1:0] t_s112;
	logic signed [VAL_W-1:0] pt_s112 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s112 <= hit_s111;
			t_s112   <= hit_s111 ? t_s111 : '0;
			for (int i = 0; i < 3; i++)
				pt_s112[i] <= hit_s111 ?
					sat32(WIDE_W'($signed(ray_s111.o[i])) + rnd_shr(WIDE_W'(tp_s111[i]))) : '0;
		end
	end

	assign out_valid    = out_valid_s112;
	assign hit          = hit_s112;
	assign hit_distance = t_s112;
	assign hit_x        = pt_s112[0];
	assign hit_y        = pt_s112[1];
	assign hit_z        = pt_s112[2];

endmodule

/* tb/tb_top.sv */
// self-checking testbench for ray_cylinder_intersection: streams rays and compares each
// result with a fixed point cylinder hit predictor; depends on rci_pkg and the block
`timescale 1ns / 1ps

module tb_top;
	import rci_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 150;
	localparam int LONG_HOLD    = 600;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
	localparam logic signed [31:0] ONE = 32'sd65536;

	typedef logic signed [255:0] big_t;

	typedef struct {
		logic signed [VAL_W-1:0] o[3];
		logic signed [VAL_W-1:0] d[3];
	} ray_item_t;

	typedef struct {
		logic                    hit;
		logic signed [VAL_W-1:0] distance;
		logic signed [VAL_W-1:0] pt[3];
	} hit_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [VAL_W-1:0] ray_origin_x = '0, ray_origin_y = '0, ray_origin_z = '0;
	logic signed [VAL_W-1:0] ray_dir_x = '0, ray_dir_y = '0, ray_dir_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic signed [VAL_W-1:0] hit_distance, hit_x, hit_y, hit_z;

	ray_cylinder_intersection dut (.*);

	always #5 clk = ~clk;

	// testbench copy of the cylinder registers
	logic [31:0] cyl_regs[8];
	ray_item_t pending_rays[$];
	hit_item_t expected_hits[$];
	int mismatches = 0;
	int cycles = 0;
	bit no_idle = 0;
	int long_reqs = 0, long_done = 0;

	// round half up to the fraction bits
	function automatic big_t round_frac(big_t x);
		return (x + (big_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic big_t clamp32(big_t x);
		if (x > big_t'(32'sh7FFF_FFFF)) return big_t'(32'sh7FFF_FFFF);
		if (x < -big_t'(64'sh8000_0000)) return -big_t'(64'sh8000_0000);
		return x;
	endfunction

	// floor of (num << frac) / den, den positive, then clamped
	function automatic big_t root_of(big_t num, big_t den);
		big_t sh, quo;
		sh = num <<< FRAC_BITS;
		quo = sh / den;
		if (sh < 0 && quo * den != sh) quo = quo - 1;
		return clamp32(quo);
	endfunction

	// integer square root rounded down
	function automatic big_t floor_sqrt(big_t v);
		big_t r, cand;
		r = 0;
		for (int b = 66; b >= 0; b--) begin
			cand = r | (big_t'(1) <<< b);
			if (cand * cand <= v) r = cand;
		end
		return r;
	endfunction

	// nearest accepted cylinder hit of one ray under the current registers
	function automatic hit_item_t predict_hit(ray_item_t ray);
		hit_item_t res;
		big_t o[3], d[3], n[3], w[2][3], pv[2][3];
		big_t s, q, a, h, cc, rr, disc, r, tn, tf, t, tmin, pt_full;
		res.hit = 1'b0;
		res.distance = '0;
		for (int i = 0; i < 3; i++) begin
			o[i] = ray.o[i];
			d[i] = ray.d[i];
			n[i] = $signed(cyl_regs[3+i][DIR_W-1:0]);
			w[0][i] = d[i];
			w[1][i] = o[i] - big_t'($signed(cyl_regs[i]));
			res.pt[i] = '0;
		end
		// strip the axial parts of direction and origin offset
		for (int k = 0; k < 2; k++) begin
			s = w[k][0] * n[0] + w[k][1] * n[1] + w[k][2] * n[2];
			q = round_frac(s);
			for (int i = 0; i < 3; i++)
				pv[k][i] = clamp32(w[k][i] - round_frac(q * n[i]));
		end
		a = 0; h = 0; cc = 0;
		for (int i = 0; i < 3; i++) begin
			a = a + pv[0][i] * pv[0][i];
			h = h + pv[0][i] * pv[1][i];
			cc = cc + pv[1][i] * pv[1][i];
		end
		if (a == 0) return res;
		rr = $signed({1'b0, cyl_regs[6][RAD_W-1:0]});
		rr = rr * rr;
		disc = h * h - a * (cc - rr);
		if (disc < 0) return res;
		r = floor_sqrt(disc);
		tn = root_of(-h - r, a);
		tf = root_of(-h + r, a);
		tmin = $signed(cyl_regs[7]);
		if (tn >= tmin) t = tn;
		else if (tf >= tmin) t = tf;
		else return res;
		res.hit = 1'b1;
		res.distance = t[31:0];
		for (int i = 0; i < 3; i++) begin
			pt_full = clamp32(o[i] + round_frac(t * d[i]));
			res.pt[i] = pt_full[31:0];
		end
		return res;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// input side: predict on every accepted item
	bit ray_taken = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_hits = {expected_hits, predict_hit(pending_rays[0])};
			void'(pending_rays.pop_front());
			ray_taken = 1;
		end
	end

	// ray driver with random idle bursts
	int in_gap = 0;
	always @(negedge clk) begin
		if (!in_valid || ray_taken) begin
			ray_taken = 0;
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				in_gap = $urandom_range(1, 18) - 1;
				in_valid <= 1'b0;
			end else if (pending_rays.size() > 0) begin
				in_valid <= 1'b1;
				ray_origin_x <= pending_rays[0].o[0];
				ray_origin_y <= pending_rays[0].o[1];
				ray_origin_z <= pending_rays[0].o[2];
				ray_dir_x <= pending_rays[0].d[0];
				ray_dir_y <= pending_rays[0].d[1];
				ray_dir_z <= pending_rays[0].d[2];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side stall bursts and the long hold-off
	int out_hold = 0;
	always @(negedge clk) begin
		if (long_reqs != long_done) begin
			long_done = long_reqs;
			out_hold = LONG_HOLD;
		end
		if (out_hold > 0) begin
			out_hold--;
			out_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			out_hold = $urandom_range(1, 18) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		hit_item_t want;
		if (out_valid && !out_stall) begin
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected item: hit %0d distance %0d", hit, hit_distance);
			end else begin
				want = expected_hits.pop_front();
				if (hit !== want.hit || hit_distance !== want.distance || hit_x !== want.pt[0]
						|| hit_y !== want.pt[1] || hit_z !== want.pt[2]) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("item mismatch: exp %0d %0d (%0d %0d %0d) got %0d %0d (%0d %0d %0d)",
							want.hit, want.distance, want.pt[0], want.pt[1], want.pt[2],
							hit, hit_distance, hit_x, hit_y, hit_z);
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_AXIS_DX, REG_AXIS_DY, REG_AXIS_DZ:
				cyl_regs[idx[2:0]] = {14'd0, val[DIR_W-1:0]};
			REG_RADIUS: cyl_regs[idx[2:0]] = {1'b0, val[RAD_W-1:0]};
			REG_AXIS_PX, REG_AXIS_PY, REG_AXIS_PZ, REG_MIN_DIST: cyl_regs[idx[2:0]] = val;
			default: ;
		endcase
	endtask

	task automatic set_cylinder(logic signed [31:0] px, py, pz, nx, ny, nz,
			logic [31:0] rad, logic signed [31:0] tmin);
		write_reg(REG_AXIS_PX, px);
		write_reg(REG_AXIS_PY, py);
		write_reg(REG_AXIS_PZ, pz);
		write_reg(REG_AXIS_DX, nx);
		write_reg(REG_AXIS_DY, ny);
		write_reg(REG_AXIS_DZ, nz);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_MIN_DIST, tmin);
	endtask

	task automatic add_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
		ray_item_t r;
		r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
		r.d[0] = dx; r.d[1] = dy; r.d[2] = dz;
		pending_rays = {pending_rays, r};
	endtask

	// wait until every item is in and every result is out
	task automatic drain();
		while (pending_rays.size() > 0 || expected_hits.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [31:0] near_val(int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	// mostly rays aimed near the axis, plus full range and axis parallel ones
	task automatic add_random_ray();
		ray_item_t r;
		int mode, k;
		mode = $urandom_range(0, 9);
		k = $urandom_range(0, 8) - 4;
		for (int i = 0; i < 3; i++) begin
			r.o[i] = $signed(cyl_regs[i]) + near_val(20 * 65536);
			r.d[i] = near_val(4 * 65536);
			if (mode == 6 || mode == 7) begin
				r.o[i] = $urandom;
				r.d[i] = $urandom;
			end else if (mode == 8) begin
				r.d[i] = $signed(cyl_regs[3+i][DIR_W-1:0]) * k;
			end else if (mode == 9) begin
				r.d[i] = ($urandom_range(0, 2) == 0) ? 32'sd0 : $signed($urandom);
			end
		end
		add_ray(r.o[0], r.o[1], r.o[2], r.d[0], r.d[1], r.d[2]);
	endtask

	task automatic random_cylinder();
		logic signed [31:0] n[3], p[3];
		logic [31:0] rad;
		int sel, ax;
		sel = $urandom_range(0, 3);
		ax = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++) begin
			n[i] = (sel == 0) ? near_val(65536) : 32'sd0;
			p[i] = ($urandom_range(0, 4) == 0) ? $signed($urandom) : near_val(50 * 65536);
		end
		if (sel == 1) n[ax] = ($urandom_range(0, 1) != 0) ? ONE : -ONE;
		if (sel >= 2) begin
			n[ax] = 32'sd46341;
			n[(ax + 1) % 3] = (sel == 2) ? 32'sd46341 : -32'sd46341;
		end
		rad = ($urandom_range(0, 5) == 0) ? {1'b0, 31'($urandom)} : $urandom_range(1, 15 * 65536);
		set_cylinder(p[0], p[1], p[2], n[0], n[1], n[2], rad,
			($urandom_range(0, 3) == 0) ? $signed($urandom) : near_val(8 * 65536));
	endtask

	initial begin
		for (int i = 0; i < 8; i++) cyl_regs[i] = '0;
		cyl_regs[REG_AXIS_DZ[2:0]] = {14'd0, AXIS_ONE};
		cyl_regs[REG_RADIUS[2:0]] = {1'b0, RAD_ONE};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rays under the reset cylinder: unit radius round the z axis
		add_ray(-5 * ONE, 0, 0, ONE, 0, 0);
		add_ray(0, 0, 0, ONE, 0, 0);
		add_ray(-5 * ONE, ONE, 0, ONE, 0, 0);
		add_ray(-5 * ONE, 2 * ONE, 0, ONE, 0, 0);
		add_ray(5 * ONE, 0, 0, ONE, 0, 0);
		add_ray(0, 0, 0, 0, 0, ONE);
		add_ray(3 * ONE, 0, 7 * ONE, 0, 0, -ONE);
		add_ray(0, 0, 0, 0, 0, 0);
		add_ray(-3 * ONE, -3 * ONE, ONE, ONE, ONE, 2 * ONE);
		add_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		add_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		add_ray(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0);
		add_ray(-2 * ONE, 0, 0, 1, 0, 0);
		add_ray(-ONE, 0, 0, 32'sh7FFF_FFFF, 1, 0);
		add_ray(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 5);
		add_ray(-ONE, -ONE, 0, -1, -1, 32'sh7FFF_FFFF);
		drain();

		// ray inside the cylinder with a distance floor, unused index ignored
		set_cylinder(ONE, -ONE, 0, ONE, 0, 0, 3 * ONE, 2 * ONE);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		add_ray(0, -ONE, 0, 0, ONE, 0);
		add_ray(0, -5 * ONE, 0, 0, ONE, 0);
		add_ray(0, 5 * ONE, 0, 0, -ONE, ONE);
		for (int i = 0; i < 60; i++) add_random_ray();
		drain();

		// extremes of the registers, with a long hold-off on the result side
		set_cylinder(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, -ONE, 0,
			32'h7FFF_FFFF, 32'sh8000_0000);
		for (int i = 0; i < 60; i++) add_random_ray();
		long_reqs++;
		for (int i = 0; i < 200; i++) add_random_ray();
		drain();
		set_cylinder(32'sh8000_0000, 0, 32'sh8000_0000, -ONE, ONE, -ONE,
			0, 32'sh7FFF_FFFF);
		for (int i = 0; i < 30; i++) add_random_ray();
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			random_cylinder();
			for (int i = 0; i < 60; i++) add_random_ray();
			drain();
		end

		// last stretch runs without idling
		random_cylinder();
		no_idle = 1;
		for (int i = 0; i < 80; i++) add_random_ray();
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
src/rci_pkg.sv
src/ray_cylinder_intersection.sv
tb/tb_top.sv
